// ----- rtl/tlld_pkg.sv -----
// ----------------------------------------------------------------------------
// tlld_pkg
// Shared types, register codes and helper functions for the leg dynamics block.
// ----------------------------------------------------------------------------
`default_nettype none

package tlld_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ITER         = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int CORDIC_LAT   = ITER + 2;
    localparam int LATENCY      = CORDIC_LAT + 4;

    localparam int CFG_IDX_W = 3;
    localparam int NUM_REGS  = 7;

    localparam logic [CFG_IDX_W-1:0] REG_HIP_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THIGH_BASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUPLING   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CALF_SELF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CALF_TOTAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THIGH_GRAV = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CALF_GRAV  = 3'd6;

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [31:0] SINE_MAX  = 32'sd1073741824;
    localparam logic signed [31:0] SINE_MIN  = -32'sd1073741824;

    typedef struct packed {
        logic signed [15:0] thigh_angle;
        logic signed [15:0] calf_angle;
        logic signed [15:0] thigh_rate;
        logic signed [15:0] calf_rate;
    } t_in;

    typedef struct packed {
        logic signed [31:0] inertia_hip;
        logic signed [31:0] inertia_thigh;
        logic signed [31:0] inertia_coupling;
        logic signed [31:0] inertia_calf;
        logic signed [31:0] coriolis_hip;
        logic signed [31:0] coriolis_thigh;
        logic signed [31:0] gravity_thigh;
        logic signed [31:0] gravity_calf;
    } t_out;

    function automatic logic signed [33:0] atan_val(input int idx);
        logic signed [33:0] v;
        case (idx)
            0:  v = 34'sh020000000;
            1:  v = 34'sh012E4051E;
            2:  v = 34'sh009FB385B;
            3:  v = 34'sh0051111D4;
            4:  v = 34'sh0028B0D43;
            5:  v = 34'sh00145D7E1;
            6:  v = 34'sh000A2F61E;
            7:  v = 34'sh000517C55;
            8:  v = 34'sh00028BE53;
            9:  v = 34'sh000145F2F;
            10: v = 34'sh0000A2F98;
            11: v = 34'sh0000517CC;
            12: v = 34'sh000028BE6;
            13: v = 34'sh0000145F3;
            14: v = 34'sh00000A2FA;
            15: v = 34'sh00000517D;
            16: v = 34'sh0000028BE;
            17: v = 34'sh00000145F;
            18: v = 34'sh000000A30;
            19: v = 34'sh000000518;
            20: v = 34'sh00000028C;
            21: v = 34'sh000000146;
            22: v = 34'sh0000000A3;
            default: v = 34'sh000000051;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
        logic signed [31:0] r;
        if (v > 70'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -70'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tlld_cordic.sv -----
// ----------------------------------------------------------------------------
// tlld_cordic
// Pipelined rotation CORDIC giving the sine of a binary angle in Q2.30.
// ----------------------------------------------------------------------------
`default_nettype none

module tlld_cordic (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [15:0] i_angle,
    output logic signed [31:0]      o_sine
);
    import tlld_pkg::*;

    logic signed [33:0] r_x [0:ITER];
    logic signed [33:0] r_y [0:ITER];
    logic signed [33:0] r_z [0:ITER];
    logic signed [31:0] r_sine;
    logic signed [16:0] n_fold;

    // fold into the right half plane
    always_comb begin
        n_fold = {i_angle[15], i_angle};
        if (n_fold > 17'sd16384) begin
            n_fold = 17'sd32768 - n_fold;
        end else if (n_fold < -17'sd16384) begin
            n_fold = -17'sd32768 - n_fold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_X0;
            r_y[0] <= '0;
            r_z[0] <= {{1{n_fold[16]}}, n_fold, 16'd0};
        end
    end

    for (genvar g = 0; g < ITER; g++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[g][33]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_val(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_val(g);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_y[ITER] > 34'(SINE_MAX)) begin
                r_sine <= SINE_MAX;
            end else if (r_y[ITER] < 34'(SINE_MIN)) begin
                r_sine <= SINE_MIN;
            end else begin
                r_sine <= r_y[ITER][31:0];
            end
        end
    end

    assign o_sine = r_sine;

endmodule

`default_nettype wire

// ----- rtl/two_link_leg_dynamics_terms.sv -----
// ----------------------------------------------------------------------------
// two_link_leg_dynamics_terms
// Inertia, Coriolis and gravity terms of a two-link leg per joint sample.
//
//   channel   signals                             direction
//   in        i_in_valid  o_in_stall  i_in_data    sample in
//   out       o_out_valid i_out_stall o_out_data   terms out
//   cfg       i_cfg_valid o_cfg_ready i_cfg_index  register write
//
// one transaction per cycle while the output is not stalled; the CORDIC
// pipeline is followed by product, round, Coriolis product and sum, and saturate stages.
// reset clears valid bits and coefficient registers.
// a stalled output freezes the whole pipeline; empty slots never block it.
// ----------------------------------------------------------------------------
`default_nettype none

module two_link_leg_dynamics_terms (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire tlld_pkg::t_in             i_in_data,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output tlld_pkg::t_out                 o_out_data,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [tlld_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]               i_cfg_data
);
    import tlld_pkg::*;

    logic [30:0] r_cfg [0:NUM_REGS-1];
    logic [LATENCY-1:0] r_vld;
    logic en;
    logic signed [15:0] n_sum;
    logic signed [31:0] s2, s12;

    // rate delay line matched to the cordic
    logic signed [15:0] r_a [0:CORDIC_LAT-1];
    logic signed [15:0] r_b [0:CORDIC_LAT-1];

    logic signed [63:0] r_pc, r_pg1, r_pg2;
    logic signed [31:0] r_ab, r_bb;
    logic signed [34:0] r_c2;
    logic signed [33:0] r_c, r_g1, r_g2, r_wh;
    logic signed [31:0] r_bb2;
    logic signed [67:0] r_mh, r_mt;
    logic signed [35:0] r_s0, r_s1, r_s2, r_gt, r_gc;
    t_out r_out;

    logic signed [65:0] n_c2w, n_cw, n_g1w, n_g2w;
    logic signed [69:0] n_ch, n_ct;

    assign en          = !(r_vld[LATENCY-1] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;
    assign n_sum       = i_in_data.thigh_angle + i_in_data.calf_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_cfg[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_HIP_BASE:   r_cfg[0] <= i_cfg_data[30:0];
                REG_THIGH_BASE: r_cfg[1] <= i_cfg_data[30:0];
                REG_COUPLING:   r_cfg[2] <= i_cfg_data[30:0];
                REG_CALF_SELF:  r_cfg[3] <= i_cfg_data[30:0];
                REG_CALF_TOTAL: r_cfg[4] <= i_cfg_data[30:0];
                REG_THIGH_GRAV: r_cfg[5] <= i_cfg_data[30:0];
                REG_CALF_GRAV:  r_cfg[6] <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LATENCY-2:0], i_in_valid};
        end
    end

    tlld_cordic u_sin_thigh (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_in_data.thigh_angle),
        .o_sine  (s2)
    );

    tlld_cordic u_sin_sum (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (n_sum),
        .o_sine  (s12)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a[0] <= i_in_data.thigh_rate;
            r_b[0] <= i_in_data.calf_rate;
            for (int k = 1; k < CORDIC_LAT; k++) begin
                r_a[k] <= r_a[k-1];
                r_b[k] <= r_b[k-1];
            end
        end
    end

    always_comb begin
        n_c2w = (66'(r_pc) <<< 1) + 66'sd536870912;
        n_cw  = 66'(r_pc) + 66'sd536870912;
        n_g1w = 66'(r_pg1) + 66'sd536870912;
        n_g2w = 66'(r_pg2) + 66'sd536870912;
        n_ch  = 70'(r_mh) + 70'sd32768;
        n_ct  = 70'(r_mt) + 70'sd32768;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // products with the sines and of the joint rates
            r_pc  <= $signed({1'b0, r_cfg[2]}) * s2;
            r_pg1 <= $signed({1'b0, r_cfg[5]}) * s2;
            r_pg2 <= $signed({1'b0, r_cfg[6]}) * s12;
            r_ab  <= r_a[CORDIC_LAT-1] * r_b[CORDIC_LAT-1];
            r_bb  <= r_b[CORDIC_LAT-1] * r_b[CORDIC_LAT-1];
            // round to q16.16
            r_c2  <= 35'(n_c2w >>> 30);
            r_c   <= 34'(n_cw >>> 30);
            r_g1  <= 34'(n_g1w >>> 30);
            r_g2  <= 34'(n_g2w >>> 30);
            r_wh  <= (34'(r_ab) <<< 1) + 34'(r_bb);
            r_bb2 <= r_bb;
            // coriolis products and sums
            r_mh  <= 68'(r_c) * 68'(r_wh);
            r_mt  <= 68'(r_c) * 68'(r_bb2);
            r_s0  <= $signed({5'd0, r_cfg[0]}) + 36'(r_c2);
            r_s1  <= $signed({5'd0, r_cfg[1]}) + 36'(r_c2);
            r_s2  <= $signed({5'd0, r_cfg[3]}) + 36'(r_c);
            r_gt  <= -36'(r_g1) - 36'(r_g2);
            r_gc  <= -36'(r_g2);
            // saturate
            r_out.inertia_hip      <= sat32(70'(r_s0));
            r_out.inertia_thigh    <= sat32(70'(r_s1));
            r_out.inertia_coupling <= sat32(70'(r_s2));
            r_out.inertia_calf     <= $signed({1'b0, r_cfg[4]});
            r_out.coriolis_hip     <= sat32(-(n_ch >>> 16));
            r_out.coriolis_thigh   <= sat32(n_ct >>> 16);
            r_out.gravity_thigh    <= sat32(70'(r_gt));
            r_out.gravity_calf     <= sat32(70'(r_gc));
        end
    end

    assign o_out_valid = r_vld[LATENCY-1];
    assign o_out_data  = r_out;

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(r_vld))
        else $error("pipeline moved while output stalled");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a waiting result");

    a_accept_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_vld[0])
        else $error("accepted transaction lost its valid bit");

endmodule

`default_nettype wire
